// ===== rtl/dssa_pkg.sv =====
// Shared types and codes for the two-stacks-in-one-store block.
// Used by the controller, datapath, top level and port checker.
package dssa_pkg;

	// request actions
	localparam logic [1:0] ACT_PUSH  = 2'd0;
	localparam logic [1:0] ACT_POP   = 2'd1;
	localparam logic [1:0] ACT_PEEK  = 2'd2;
	localparam logic [1:0] ACT_QUERY = 2'd3;

	// result status codes
	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_OVERFLOW = 2'd1;
	localparam logic [1:0] STS_EMPTY    = 2'd2;
	localparam logic [1:0] STS_UNUSED   = 2'd3;

	typedef struct packed {
		logic [1:0]         action;
		logic               stack_select;
		logic signed [31:0] push_value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] read_value;
		logic               empty_flag;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_SHIFT_END,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       load_req;
		logic       push_simple;
		logic       read_top;
		logic       pop_adv;
		logic       shift_init;
		logic       shift_rd;
		logic       shift_wr;
		logic       shift_end;
		logic       sts_we;
		logic [1:0] sts_code;
		logic       emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] act;
		logic       full;
		logic       sel_empty;
		logic       at_end;
		logic       shift_none;
		logic       shift_last;
	} stat_t;

endpackage

// ===== rtl/dssa_ctrl.sv =====
// Sequencer for the shared-store stacks: decodes a request, runs the
// one-entry-at-a-time slide of the store, and owns the response valid.
// Depends on dssa_pkg.
module dssa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  dssa_pkg::stat_t stat,
	output dssa_pkg::cmd_t  cmd
);
	import dssa_pkg::*;

	state_t state_q, state_nx;
	logic   rsp_valid_q;
	logic   emit_ok;

	assign emit_ok   = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_nx = S_DECODE;
			end
			S_DECODE: begin
				state_nx = S_DONE;
				if (stat.act == ACT_PUSH && !stat.full && stat.at_end) begin
					state_nx = stat.shift_none ? S_SHIFT_END : S_SHIFT_RD;
				end
			end
			S_SHIFT_RD: state_nx = S_SHIFT_WR;
			S_SHIFT_WR: begin
				state_nx = stat.shift_last ? S_SHIFT_END : S_SHIFT_RD;
			end
			S_SHIFT_END: state_nx = S_DONE;
			S_DONE: begin
				if (emit_ok) state_nx = req_valid ? S_DECODE : S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready    = 1'b1;
				cmd.load_req = req_valid;
			end
			S_DECODE: begin
				cmd.sts_we   = 1'b1;
				cmd.sts_code = STS_OK;
				case (stat.act)
					ACT_PUSH: begin
						if (stat.full) begin
							cmd.sts_code = STS_OVERFLOW;
						end else if (!stat.at_end) begin
							cmd.push_simple = 1'b1;
						end else if (!stat.shift_none) begin
							cmd.shift_init = 1'b1;
						end
					end
					ACT_POP, ACT_PEEK: begin
						if (stat.sel_empty) begin
							cmd.sts_code = STS_EMPTY;
						end else begin
							cmd.read_top = 1'b1;
							cmd.pop_adv  = (stat.act == ACT_POP);
						end
					end
					default: cmd.sts_code = STS_OK;
				endcase
			end
			S_SHIFT_RD:  cmd.shift_rd  = 1'b1;
			S_SHIFT_WR:  cmd.shift_wr  = 1'b1;
			S_SHIFT_END: cmd.shift_end = 1'b1;
			S_DONE: begin
				// result leaves and the next request may enter in the same cycle
				cmd.emit     = emit_ok;
				req_ready    = emit_ok;
				cmd.load_req = emit_ok && req_valid;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== rtl/dssa_dp.sv =====
// Datapath: entry store (one write, one registered read port), stack
// pointers, boundary, slide cursor and the response register.
// Depends on dssa_pkg; driven by dssa_ctrl commands.
module dssa_dp #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dssa_pkg::req_t  req_data,
	input  dssa_pkg::cmd_t  cmd,
	output dssa_pkg::stat_t stat,
	output dssa_pkg::rsp_t  rsp_data
);
	import dssa_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);
	localparam logic [PW-1:0] HALF_P  = PW'(DEPTH / 2);
	localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	// lo_q is one above the next free slot of stack 0
	logic [PW-1:0] lo_q, hi_q, bnd_q;
	logic [AW-1:0] cur_q;

	logic [1:0]            act_q;
	logic                  sel_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [1:0]            sts_q;
	rsp_t                  rsp_q;

	logic [PW-1:0]         lo_m1, hi_m1;
	logic                  sel_empty;
	logic                  we, re;
	logic [AW-1:0]         waddr, raddr;
	logic [DATA_WIDTH-1:0] wdata;
	logic signed [63:0]    push_wide;
	logic signed [DATA_WIDTH-1:0] rd_signed;
	logic signed [63:0]    rd_wide;

	assign lo_m1 = lo_q - PW'(1);
	assign hi_m1 = hi_q - PW'(1);
	assign sel_empty = sel_q ? (bnd_q == hi_q) : (bnd_q == lo_q);

	assign stat.act        = act_q;
	assign stat.full       = (lo_q == '0) && (hi_q == DEPTH_P);
	assign stat.sel_empty  = sel_empty;
	assign stat.at_end     = sel_q ? (hi_q == DEPTH_P) : (lo_q == '0);
	assign stat.shift_none = sel_q ? (lo_q == DEPTH_P) : (hi_q == '0);
	assign stat.shift_last = sel_q ? (cur_q == LAST_A) : (cur_q == '0);

	assign push_wide = 64'(req_data.push_value);
	assign rd_signed = rdata_q;
	assign rd_wide   = 64'(rd_signed);

	// write port select
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = val_q;
		if (cmd.push_simple) begin
			we    = 1'b1;
			waddr = sel_q ? hi_q[AW-1:0] : lo_m1[AW-1:0];
		end else if (cmd.shift_wr) begin
			we    = 1'b1;
			waddr = sel_q ? (cur_q - AW'(1)) : (cur_q + AW'(1));
			wdata = rdata_q;
		end else if (cmd.shift_end) begin
			we    = 1'b1;
			waddr = sel_q ? LAST_A : '0;
		end
	end

	assign re    = cmd.read_top || cmd.shift_rd;
	assign raddr = cmd.shift_rd ? cur_q : (sel_q ? hi_m1[AW-1:0] : lo_q[AW-1:0]);

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q  <= HALF_P;
			hi_q  <= HALF_P;
			bnd_q <= HALF_P;
			cur_q <= '0;
		end else begin
			if (cmd.push_simple) begin
				if (sel_q) hi_q <= hi_q + PW'(1);
				else       lo_q <= lo_m1;
			end
			if (cmd.pop_adv) begin
				if (sel_q) hi_q <= hi_m1;
				else       lo_q <= lo_q + PW'(1);
			end
			if (cmd.shift_init) begin
				cur_q <= sel_q ? lo_q[AW-1:0] : hi_m1[AW-1:0];
			end
			if (cmd.shift_wr) begin
				// walk toward the end that is being freed
				cur_q <= sel_q ? (cur_q + AW'(1)) : (cur_q - AW'(1));
			end
			if (cmd.shift_end) begin
				if (sel_q) begin
					bnd_q <= bnd_q - PW'(1);
					lo_q  <= lo_m1;
				end else begin
					bnd_q <= bnd_q + PW'(1);
					hi_q  <= hi_q + PW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			act_q <= req_data.action;
			sel_q <= req_data.stack_select;
			val_q <= push_wide[DATA_WIDTH-1:0];
		end
		if (cmd.sts_we) sts_q <= cmd.sts_code;
		if (cmd.emit) begin
			rsp_q.status     <= sts_q;
			rsp_q.empty_flag <= sel_empty;
			if (sts_q == STS_OK && (act_q == ACT_POP || act_q == ACT_PEEK)) begin
				rsp_q.read_value <= rd_wide[31:0];
			end else begin
				rsp_q.read_value <= '0;
			end
		end
	end

	assign rsp_data = rsp_q;

endmodule

// ===== rtl/dual_stack_shared_array_unit.sv =====
// Two stacks in one shared entry store with a movable boundary.
// Usage:
//   Requests enter on req_valid/req_ready with req_data (action, stack_select,
//   push_value); one result beat per request leaves on rsp_valid/rsp_ready
//   with rsp_data (status, read_value, empty_flag).
//   One request is in work at a time. Push without slide, pop, peek, query
//   and overflow pass through the decode and done states to the result
//   register; the next request is accepted in the cycle the result is loaded.
//   A push onto a stack that sits at its end of the store slides the other
//   occupied entries by one place through the single store port, reading and
//   then writing each moved entry before the new value is written at the end.
//   A result waiting in the output register does not block the next request
//   from being accepted; if the receiver stalls, the block holds the finished
//   result internally and drops req_ready until the output register frees.
//   Reset puts both stacks empty with the boundary at DEPTH/2; store
//   contents are not cleared and are only read after being written.
// Depends on dssa_pkg, dssa_ctrl, dssa_dp.
module dual_stack_shared_array_unit #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  dssa_pkg::req_t req_data,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output dssa_pkg::rsp_t rsp_data
);
	import dssa_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	dssa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	dssa_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req_data),
		.cmd      (cmd),
		.stat     (stat),
		.rsp_data (rsp_data)
	);

endmodule

// ===== rtl/dssa_checker.sv =====
// Port-level checks for dual_stack_shared_array_unit, attached by bind.
// Depends on dssa_pkg.
module dssa_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input dssa_pkg::req_t req_data,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input dssa_pkg::rsp_t rsp_data
);
	import dssa_pkg::*;

	// hold a stalled result beat
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result beat dropped or changed while stalled");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != STS_OK |-> rsp_data.read_value == '0)
		else $error("read_value nonzero on failed request");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == STS_EMPTY |-> rsp_data.empty_flag)
		else $error("empty status without empty flag");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while previous one in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.status != STS_UNUSED)
		else $error("undefined status code");

endmodule

bind dual_stack_shared_array_unit dssa_checker u_dssa_checker (.*);
